// ----- sv/rpu_pkg.sv -----
// Shared types and codes for the relocation patch unit.
// Relocation type codes, status codes and the stage payload structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rpu_pkg;

	// Default width of the offset and section size fields that take part in the math.
	localparam int OffsetWidthDefault = 32;

	// Relocation type codes.
	localparam logic [3:0] RT_X86_64    = 4'd0;
	localparam logic [3:0] RT_X86_PC32  = 4'd1;
	localparam logic [3:0] RT_X86_32    = 4'd2;
	localparam logic [3:0] RT_X86_32S   = 4'd3;
	localparam logic [3:0] RT_X86_PC64  = 4'd4;
	localparam logic [3:0] RT_X86_PLT32 = 4'd5;
	localparam logic [3:0] RT_X86_GOTPC = 4'd6;
	localparam logic [3:0] RT_A64_ABS64 = 4'd7;
	localparam logic [3:0] RT_A64_ABS32 = 4'd8;
	localparam logic [3:0] RT_A64_CALL  = 4'd9;
	localparam logic [3:0] RT_A64_JUMP  = 4'd10;
	localparam logic [3:0] RT_A64_ADRP  = 4'd11;
	localparam logic [3:0] RT_A64_ADD12 = 4'd12;
	localparam logic [3:0] RT_A64_LDST  = 4'd13;

	// Result status codes.
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BAD_TYPE = 3'd1;
	localparam logic [2:0] ST_OUTSIDE  = 3'd2;
	localparam logic [2:0] ST_RANGE    = 3'd3;
	localparam logic [2:0] ST_ALIGN    = 3'd4;
	localparam logic [2:0] ST_PAST_END = 3'd5;

	// Architecture select values.
	localparam logic ARCH_X86 = 1'b0;

	// Instruction masks for the AArch64 patches.
	localparam logic [31:0] MaskBranch = 32'hFC000000;
	localparam logic [31:0] MaskAdrp   = 32'h9F00001F;
	localparam logic [31:0] MaskImm12  = 32'hFFC003FF;

	// Payload after the address stage.
	typedef struct packed {
		logic [3:0]  rtype;
		logic        type_ok;
		logic        outside;
		logic        room_lt4;
		logic        room_lt8;
		logic [31:0] word;
		logic [63:0] sa;
		logic [63:0] place;
	} addr_t;

	// Payload after the difference stage.
	typedef struct packed {
		logic [3:0]  rtype;
		logic        type_ok;
		logic        outside;
		logic        room_lt4;
		logic        room_lt8;
		logic [31:0] word;
		logic [63:0] sa;
		logic [63:0] pc;
		logic [51:0] pdiff;
	} diff_t;

endpackage

`default_nettype wire

// ----- sv/rpu_addr_stage.sv -----
// First pipeline stage: symbol plus addend, place address, type and bounds checks.
// Depends on rpu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpu_addr_stage import rpu_pkg::*; #(
	parameter int OFFSET_WIDTH = OffsetWidthDefault
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_valid,
	input  wire logic               arch,
	input  wire logic [3:0]         req_type,
	input  wire logic [63:0]        sym_addr,
	input  wire logic signed [63:0] addend,
	input  wire logic [31:0]        field_offset,
	input  wire logic [63:0]        section_base,
	input  wire logic [31:0]        section_bytes,
	input  wire logic [31:0]        existing_word,
	output logic                    valid_s1,
	output addr_t                   data_s1
);

	// Only the low bits of offset and size take part, at most the 32 the ports carry.
	localparam int OW = (OFFSET_WIDTH < 32) ? OFFSET_WIDTH : 32;

	logic [OW-1:0] ofs;
	logic [OW-1:0] size;
	logic [OW-1:0] room;
	addr_t         nxt;

	// Masked offset and size, and the bytes left from the offset to the section end.
	assign ofs  = field_offset[OW-1:0];
	assign size = section_bytes[OW-1:0];
	assign room = size - ofs;

	always_comb begin
		nxt.rtype    = req_type;
		if (arch == ARCH_X86) begin
			nxt.type_ok = (req_type <= RT_X86_GOTPC);
		end else begin
			nxt.type_ok = (req_type >= RT_A64_ABS64) && (req_type <= RT_A64_LDST);
		end
		nxt.outside  = (ofs >= size);
		nxt.room_lt4 = (room < OW'(4));
		nxt.room_lt8 = (room < OW'(8));
		nxt.word     = existing_word;
		nxt.sa       = sym_addr + $unsigned(addend);
		nxt.place    = section_base + {{(64-OW){1'b0}}, ofs};
	end

	// Stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			data_s1 <= nxt;
		end
	end

endmodule

`default_nettype wire

// ----- sv/rpu_diff_stage.sv -----
// Second pipeline stage: PC-relative difference and page difference.
// Depends on rpu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpu_diff_stage import rpu_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  en,
	input  wire logic  valid_s1,
	input  wire addr_t data_s1,
	output logic       valid_s2,
	output diff_t      data_s2
);

	diff_t nxt;

	// The PC difference is a 64-bit subtraction; the page one subtracts bits 63:12 only.
	always_comb begin
		nxt.rtype    = data_s1.rtype;
		nxt.type_ok  = data_s1.type_ok;
		nxt.outside  = data_s1.outside;
		nxt.room_lt4 = data_s1.room_lt4;
		nxt.room_lt8 = data_s1.room_lt8;
		nxt.word     = data_s1.word;
		nxt.sa       = data_s1.sa;
		nxt.pc       = data_s1.sa - data_s1.place;
		nxt.pdiff    = data_s1.sa[63:12] - data_s1.place[63:12];
	end

	// Stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (en && valid_s1) begin
			data_s2 <= nxt;
		end
	end

endmodule

`default_nettype wire

// ----- sv/rpu_patch_stage.sv -----
// Third pipeline stage: range checks, field assembly and status priority.
// Its registers drive the result ports. Depends on rpu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpu_patch_stage import rpu_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  en,
	input  wire logic  valid_s2,
	input  wire diff_t data_s2,
	output logic       valid_s3,
	output logic [2:0] status_s3,
	output logic [63:0] value_s3,
	output logic [3:0]  bytes_s3
);

	logic        pc_fits32;
	logic        sa_fits32;
	logic        sa_fitsu32;
	logic        pc_fits28;
	logic        pg_fits21;
	logic        err;
	logic        wide;
	logic [2:0]  st;
	logic [63:0] val;
	logic [3:0]  nbytes;

	// Window checks: for signed ones the upper bits must match the sign bit, else be zero.
	assign pc_fits32  = (&data_s2.pc[63:31]) || !(|data_s2.pc[63:31]);
	assign sa_fits32  = (&data_s2.sa[63:31]) || !(|data_s2.sa[63:31]);
	assign sa_fitsu32 = !(|data_s2.sa[63:32]);
	assign pc_fits28  = (&data_s2.pc[63:27]) || !(|data_s2.pc[63:27]);
	assign pg_fits21  = (&data_s2.pdiff[51:20]) || !(|data_s2.pdiff[51:20]);

	// Per-type value and the range or alignment error.
	always_comb begin
		err  = 1'b0;
		wide = 1'b0;
		st   = ST_RANGE;
		val  = 64'd0;
		case (data_s2.rtype)
			RT_X86_64, RT_A64_ABS64: begin
				val  = data_s2.sa;
				wide = 1'b1;
			end
			RT_X86_PC64: begin
				val  = data_s2.pc;
				wide = 1'b1;
			end
			RT_X86_PC32, RT_X86_PLT32, RT_X86_GOTPC: begin
				err = !pc_fits32;
				val = {32'd0, data_s2.pc[31:0]};
			end
			RT_X86_32, RT_A64_ABS32: begin
				err = !sa_fitsu32;
				val = {32'd0, data_s2.sa[31:0]};
			end
			RT_X86_32S: begin
				err = !sa_fits32;
				val = {32'd0, data_s2.sa[31:0]};
			end
			RT_A64_CALL, RT_A64_JUMP: begin
				err = !pc_fits28;
				val = {32'd0, (data_s2.word & MaskBranch) | {6'd0, data_s2.pc[27:2]}};
			end
			RT_A64_ADRP: begin
				err = !pg_fits21;
				val = {32'd0, (data_s2.word & MaskAdrp) | {1'b0, data_s2.pdiff[1:0], 5'd0,
					data_s2.pdiff[20:2], 5'd0}};
			end
			RT_A64_ADD12: begin
				val = {32'd0, (data_s2.word & MaskImm12) | {10'd0, data_s2.sa[11:0], 10'd0}};
			end
			default: begin
				// Doubleword load or store: the low offset must be a multiple of eight.
				err = |data_s2.sa[2:0];
				st  = ST_ALIGN;
				val = {32'd0, (data_s2.word & MaskImm12) | {13'd0, data_s2.sa[11:3], 10'd0}};
			end
		endcase
	end

	// Status in priority order; any error clears value and size.
	always_comb begin
		logic [2:0] fst;
		fst = ST_OK;
		if (!data_s2.type_ok) begin
			fst = ST_BAD_TYPE;
		end else if (data_s2.outside) begin
			fst = ST_OUTSIDE;
		end else if (err) begin
			fst = st;
		end else if (wide ? data_s2.room_lt8 : data_s2.room_lt4) begin
			fst = ST_PAST_END;
		end
		nbytes = (fst != ST_OK) ? 4'd0 : (wide ? 4'd8 : 4'd4);
	end

	// Stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	// Result registers.
	always_ff @(posedge clk) begin
		if (en && valid_s2) begin
			bytes_s3 <= nbytes;
			if (nbytes == 4'd0) begin
				value_s3 <= 64'd0;
				if (!data_s2.type_ok) begin
					status_s3 <= ST_BAD_TYPE;
				end else if (data_s2.outside) begin
					status_s3 <= ST_OUTSIDE;
				end else if (err) begin
					status_s3 <= st;
				end else begin
					status_s3 <= ST_PAST_END;
				end
			end else begin
				value_s3  <= val;
				status_s3 <= ST_OK;
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/relocation_patch_unit.sv -----
// Top level of the relocation patch unit: configuration register, stall chain
// and the three pipeline stages. Depends on rpu_pkg and the rpu stage modules.
//
//   Channel   Direction  Handshake                 Payload
//   in        in         in_valid / in_stall       req_type .. existing_word
//   out       out        out_valid / out_stall     status, patched_value, write_bytes
//   config    in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// An accepted item passes through the address, difference and patch stage
// registers in that order to the output ports. One item is accepted every cycle
// while in_stall is low; the three stage registers set the latency.
// Each stage holds its item while the next one is full and stalled, so a stall
// backs up stage by stage and empty stages still fill.
// Reset clears all stage valid bits and selects the x86-64 architecture.
`timescale 1ns / 1ps
`default_nettype none

module relocation_patch_unit import rpu_pkg::*; #(
	parameter int OFFSET_WIDTH = OffsetWidthDefault
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [3:0]         req_type,
	input  wire logic [63:0]        sym_addr,
	input  wire logic signed [63:0] addend,
	input  wire logic [31:0]        field_offset,
	input  wire logic [63:0]        section_base,
	input  wire logic [31:0]        section_bytes,
	input  wire logic [31:0]        existing_word,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [2:0]              status,
	output logic [63:0]             patched_value,
	output logic [3:0]              write_bytes
);

	logic  arch_q;
	logic  en1;
	logic  en2;
	logic  en3;
	logic  valid_s1;
	logic  valid_s2;
	addr_t data_s1;
	diff_t data_s2;

	// Configuration register: the architecture select at byte addresses 0 to 3 (paddr[2] low).
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {31'd0, arch_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arch_q <= ARCH_X86;
		end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
			arch_q <= pwdata[0];
		end
	end

	// A stage moves when the stage after it is empty or moves as well.
	assign en3      = !out_valid || !out_stall;
	assign en2      = !valid_s2 || en3;
	assign en1      = !valid_s1 || en2;
	assign in_stall = !en1;

	rpu_addr_stage #(
		.OFFSET_WIDTH(OFFSET_WIDTH)
	) u_addr (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en1),
		.in_valid       (in_valid),
		.arch           (arch_q),
		.req_type       (req_type),
		.sym_addr       (sym_addr),
		.addend         (addend),
		.field_offset   (field_offset),
		.section_base   (section_base),
		.section_bytes  (section_bytes),
		.existing_word  (existing_word),
		.valid_s1       (valid_s1),
		.data_s1        (data_s1)
	);

	rpu_diff_stage u_diff (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en2),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2)
	);

	rpu_patch_stage u_patch (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en3),
		.valid_s2  (valid_s2),
		.data_s2   (data_s2),
		.valid_s3  (out_valid),
		.status_s3 (status),
		.value_s3  (patched_value),
		.bytes_s3  (write_bytes)
	);

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for relocation_patch_unit: directed and random relocations
// for both architectures, random idling on both sides, APB writes between phases.
// Depends on rpu_pkg and the relocation_patch_unit RTL.

module testbench;
	import rpu_pkg::*;

	localparam int          OfsW      = OffsetWidthDefault;
	localparam logic [2:0]  ADDR_ARCH = 3'd0;
	localparam int          PhaseLen  = 130;
	localparam int          MaxShown  = 10;

	// One relocation request and the patch it produces.
	typedef struct packed {
		logic [3:0]  rtype;
		logic [63:0] sym;
		logic [63:0] add;
		logic [31:0] ofs;
		logic [63:0] base;
		logic [31:0] size;
		logic [31:0] word;
	} reloc_t;

	typedef struct packed {
		logic [2:0]  st;
		logic [63:0] val;
		logic [3:0]  nbytes;
	} patch_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_stall;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [63:0] patched_value;
	logic [3:0]  write_bytes;

	// Driver state.
	reloc_t      drv_item = '0;
	logic        drv_valid = 1'b0;
	int unsigned gap_left = 0;
	reloc_t      pending_relocs[$];
	bit          send_burst = 1'b0;

	// Monitor state.
	int unsigned stall_left = 0;
	patch_t      expected_patches[$];
	bit          recv_burst = 1'b0;

	// Predictor copy of the configuration and run counters.
	logic        arch_model = ARCH_X86;
	int unsigned n_sent = 0;
	int unsigned n_checked = 0;
	int unsigned n_errors = 0;
	int unsigned n_settings = 1;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	relocation_patch_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (drv_valid),
		.in_stall       (in_stall),
		.req_type       (drv_item.rtype),
		.sym_addr       (drv_item.sym),
		.addend         (drv_item.add),
		.field_offset   (drv_item.ofs),
		.section_base   (drv_item.base),
		.section_bytes  (drv_item.size),
		.existing_word  (drv_item.word),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.patched_value  (patched_value),
		.write_bytes    (write_bytes)
	);

	// True when v, read as signed, fits a signed 32-bit field.
	function automatic logic fits_s32(logic [63:0] v);
		return (v + 64'h80000000) <= 64'hFFFFFFFF;
	endfunction

	// Computes the patch that one relocation yields under the given architecture.
	function automatic patch_t predict_patch(reloc_t r, logic arch);
		logic [63:0] ofs_mask;
		logic [63:0] ofs;
		logic [63:0] size;
		logic [63:0] place;
		logic [63:0] sa;
		logic [63:0] pc;
		logic [63:0] pdiff;
		logic        type_ok;
		patch_t      p;
		ofs_mask = (OfsW >= 64) ? '1 : ((64'd1 << OfsW) - 64'd1);
		ofs   = {32'b0, r.ofs} & ofs_mask;
		size  = {32'b0, r.size} & ofs_mask;
		place = r.base + ofs;
		sa    = r.sym + r.add;
		pc    = sa - place;
		p.st     = ST_OK;
		p.val    = '0;
		p.nbytes = 4'd4;
		if (arch == ARCH_X86)
			type_ok = r.rtype <= RT_X86_GOTPC;
		else
			type_ok = r.rtype >= RT_A64_ABS64 && r.rtype <= RT_A64_LDST;

		if (!type_ok) begin
			p.st = ST_BAD_TYPE;
		end else if (ofs >= size) begin
			p.st = ST_OUTSIDE;
		end else begin
			case (r.rtype)
				RT_X86_64, RT_A64_ABS64: begin
					p.val    = sa;
					p.nbytes = 4'd8;
				end
				RT_X86_PC64: begin
					p.val    = pc;
					p.nbytes = 4'd8;
				end
				RT_X86_PC32, RT_X86_PLT32, RT_X86_GOTPC: begin
					if (!fits_s32(pc))
						p.st = ST_RANGE;
					else
						p.val = {32'b0, pc[31:0]};
				end
				RT_X86_32, RT_A64_ABS32: begin
					if (sa > 64'hFFFFFFFF)
						p.st = ST_RANGE;
					else
						p.val = sa;
				end
				RT_X86_32S: begin
					if (!fits_s32(sa))
						p.st = ST_RANGE;
					else
						p.val = {32'b0, sa[31:0]};
				end
				RT_A64_CALL, RT_A64_JUMP: begin
					// Branch reach is a signed 28-bit byte window; the low two bits are dropped.
					if (pc + 64'h8000000 > 64'hFFFFFFF)
						p.st = ST_RANGE;
					else
						p.val = {32'b0, (r.word & MaskBranch) | {6'b0, pc[27:2]}};
				end
				RT_A64_ADRP: begin
					pdiff = {sa[63:12], 12'b0} - {place[63:12], 12'b0};
					if (pdiff + 64'h100000000 > 64'h1FFFFF000)
						p.st = ST_RANGE;
					else
						p.val = {32'b0, (r.word & MaskAdrp) |
							{1'b0, pdiff[13:12], 5'b0, pdiff[32:14], 5'b0}};
				end
				RT_A64_ADD12: begin
					p.val = {32'b0, (r.word & MaskImm12) | {10'b0, sa[11:0], 10'b0}};
				end
				default: begin
					// The doubleword load/store immediate is scaled by eight.
					if (sa[2:0] != 3'b0)
						p.st = ST_ALIGN;
					else
						p.val = {32'b0, (r.word & MaskImm12) | {13'b0, sa[11:3], 10'b0}};
				end
			endcase
			if (p.st == ST_OK && (size - ofs) < {60'b0, p.nbytes})
				p.st = ST_PAST_END;
		end

		if (p.st != ST_OK) begin
			p.val    = '0;
			p.nbytes = '0;
		end
		return p;
	endfunction

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	function automatic reloc_t reloc_item(logic [3:0] t, logic [63:0] sym, logic [63:0] add,
			logic [31:0] ofs, logic [63:0] base, logic [31:0] size, logic [31:0] word);
		reloc_t r;
		r.rtype = t;
		r.sym   = sym;
		r.add   = add;
		r.ofs   = ofs;
		r.base  = base;
		r.size  = size;
		r.word  = word;
		return r;
	endfunction

	// Builds a random relocation, mostly of a type the architecture accepts, with
	// values steered near the range limits of the chosen type.
	function automatic reloc_t rand_reloc(logic arch);
		reloc_t      r;
		logic [63:0] place;
		logic [63:0] delta;
		logic [63:0] target;
		longint      jitter;
		int unsigned k;
		bit          pc_rel;
		if ($urandom_range(0, 9) < 8)
			r.rtype = (arch == ARCH_X86) ? 4'($urandom_range(0, 6)) : 4'($urandom_range(7, 13));
		else
			r.rtype = 4'($urandom_range(0, 15));

		k = $urandom_range(0, 9);
		if (k <= 5)
			r.size = $urandom_range(1, 64);
		else if (k <= 7)
			r.size = $urandom;
		else if (k == 8)
			r.size = 32'hFFFFFFFF;
		else
			r.size = $urandom_range(0, 8);

		// Offsets fall mostly inside, often close to the end, sometimes past it.
		k = $urandom_range(0, 9);
		if (r.size == 0)
			r.ofs = (k == 9) ? $urandom : 32'd0;
		else if (k <= 5)
			r.ofs = $urandom_range(0, r.size - 1);
		else if (k <= 8)
			r.ofs = r.size - $urandom_range(1, (r.size < 8) ? r.size : 8);
		else
			r.ofs = (k == 9 && $urandom_range(0, 1)) ? r.size + $urandom_range(0, 3) : $urandom;

		r.base = rnd64();
		r.word = $urandom;
		place  = r.base + {32'b0, r.ofs};
		jitter = longint'($urandom_range(0, 8)) - 4;
		k      = $urandom_range(0, 5);
		case (k)
			0: delta = {{44{$urandom_range(0, 1) == 1}}, 20'($urandom)};
			1: delta = ($urandom_range(0, 1) ? 64'h80000000 : 64'hFFFFFFFF80000000) + jitter;
			2: delta = ($urandom_range(0, 1) ? 64'h8000000 : 64'hFFFFFFFFF8000000) + jitter;
			3: begin
				case ($urandom_range(0, 2))
					0: delta = 64'h100000000;
					1: delta = 64'hFFFFFFFF00000000;
					default: delta = 64'hFFFFF000;
				endcase
				delta = delta + (jitter <<< 12) + $urandom_range(0, 4095);
			end
			4: delta = rnd64();
			default: delta = $urandom_range(0, 4096);
		endcase

		pc_rel = r.rtype inside {RT_X86_PC32, RT_X86_PC64, RT_X86_PLT32, RT_X86_GOTPC,
			RT_A64_CALL, RT_A64_JUMP, RT_A64_ADRP};
		target = pc_rel ? place + delta : delta;
		if (r.rtype == RT_A64_LDST && $urandom_range(0, 1))
			target[2:0] = 3'b0;

		if ($urandom_range(0, 3) == 0) begin
			r.add = 64'(jitter * longint'($urandom_range(0, 1000)));
			r.sym = target - r.add;
		end else begin
			r.sym = rnd64();
			r.add = target - r.sym;
		end
		return r;
	endfunction

	// Driver: presents pending relocations with a random gap after each one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
			gap_left  <= 0;
		end else begin
			if (drv_valid && !in_stall) begin
				expected_patches.push_back(predict_patch(drv_item, arch_model));
				n_sent++;
			end
			if (!drv_valid || !in_stall) begin
				if (gap_left != 0) begin
					drv_valid <= 1'b0;
					gap_left  <= gap_left - 1;
				end else if (pending_relocs.size() != 0) begin
					drv_item  <= pending_relocs.pop_front();
					drv_valid <= 1'b1;
					gap_left  <= send_burst ? 0 : $urandom_range(0, 7);
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result against the oldest expected patch and stalls at random.
	always @(posedge clk or negedge arst_n) begin
		patch_t      want;
		int unsigned hold;
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else if (out_valid && !out_stall) begin
			if (expected_patches.size() == 0) begin
				n_errors++;
				if (n_errors <= MaxShown)
					$display("[%0t] unexpected result: status %0d value %h bytes %0d",
						$realtime, status, patched_value, write_bytes);
			end else begin
				want = expected_patches.pop_front();
				n_checked++;
				if (status !== want.st || patched_value !== want.val ||
						write_bytes !== want.nbytes) begin
					n_errors++;
					if (n_errors <= MaxShown)
						$display("[%0t] mismatch: want st %0d val %h n %0d, got %0d %h %0d",
							$realtime, want.st, want.val, want.nbytes,
							status, patched_value, write_bytes);
				end
			end
			hold = recv_burst ? 0 : $urandom_range(0, 7);
			out_stall  <= hold != 0;
			stall_left <= (hold == 0) ? 0 : hold - 1;
		end else if (stall_left != 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Waits until the sender is empty and every expected result has come back.
	task automatic drain();
		while (pending_relocs.size() != 0 || drv_valid || expected_patches.size() != 0)
			@(negedge clk);
	endtask

	// Writes the architecture select over APB, then reads it back.
	task automatic write_arch(logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_ARCH;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		arch_model = value[0];
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[0] !== arch_model) begin
			n_errors++;
			if (n_errors <= MaxShown)
				$display("[%0t] architecture select read back %b, expected %b",
					$realtime, prdata[0], arch_model);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		n_settings++;
	endtask

	// Stimulus sequence: directed items per architecture, then random phases.
	initial begin
		logic [63:0] b86;
		logic [63:0] b64;
		logic [31:0] wval;
		b86 = 64'h00007FFFF0001000;
		b64 = 64'h0000004000000000;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// x86-64 under the reset setting: limits of each type, bounds and priorities.
		pending_relocs.push_back(reloc_item(RT_X86_64, '1, 64'd1, 0, b86, 8, 0));
		pending_relocs.push_back(reloc_item(RT_X86_PC32, b86 + 16, 64'h7FFFFFFF, 16, b86, 64,
			$urandom));
		pending_relocs.push_back(reloc_item(RT_X86_PC32, b86 + 16, 64'h80000000, 16, b86, 18, 0));
		pending_relocs.push_back(reloc_item(RT_X86_PLT32, b86 + 16, 64'hFFFFFFFF80000000, 16,
			b86, 20, 0));
		pending_relocs.push_back(reloc_item(RT_X86_GOTPC, b86 + 16, 64'hFFFFFFFF7FFFFFFF, 16,
			b86, 20, 0));
		pending_relocs.push_back(reloc_item(RT_X86_32, 64'hFFFFFFFF, 0, 0, 0, 4, 0));
		pending_relocs.push_back(reloc_item(RT_X86_32, 64'h100000000, 0, 0, 0, 4, 0));
		pending_relocs.push_back(reloc_item(RT_X86_32S, 0, 64'hFFFFFFFF80000000, 4, '1, 8, '1));
		pending_relocs.push_back(reloc_item(RT_X86_PC64, rnd64(), rnd64(), 32'hFFFFFFF7, b86,
			32'hFFFFFFFF, 0));
		pending_relocs.push_back(reloc_item(RT_X86_64, 0, 0, 32, b86, 32, 0));
		pending_relocs.push_back(reloc_item(RT_X86_64, 0, 0, 8, b86, 12, 0));
		pending_relocs.push_back(reloc_item(RT_X86_32, 0, 0, 0, b86, 0, 0));
		pending_relocs.push_back(reloc_item(RT_A64_CALL, 0, 0, 0, b86, 64, 0));
		pending_relocs.push_back(reloc_item(4'd15, 64'h100000000, 0, 40, b86, 8, 0));
		drain();

		// AArch64: branch and page windows at their edges, alignment before size.
		write_arch(32'hFFFFFFFF);
		pending_relocs.push_back(reloc_item(RT_A64_ABS64, '1, 0, 0, b64, 8, 0));
		pending_relocs.push_back(reloc_item(RT_A64_ABS32, 64'hFFFFFFFF, 1, 0, b64, 4, 0));
		pending_relocs.push_back(reloc_item(RT_A64_CALL, b64 + 4 + 64'h7FFFFFF, 0, 4, b64, 8, '1));
		pending_relocs.push_back(reloc_item(RT_A64_JUMP, b64 - 64'h7FFFFFC, 0, 4, b64, 8, 0));
		pending_relocs.push_back(reloc_item(RT_A64_ADRP, b64 + 64'hFFFFFABC, 0, 0, b64, 4, '1));
		pending_relocs.push_back(reloc_item(RT_A64_ADRP, b64 - 64'h100000000 + 64'h123, 0, 0,
			b64, 4, '1));
		pending_relocs.push_back(reloc_item(RT_A64_ADRP, b64 + 64'h100000000, 0, 0, b64, 4, 0));
		pending_relocs.push_back(reloc_item(RT_A64_ADD12, 64'hFFF, 0, 0, b64, 4, $urandom));
		pending_relocs.push_back(reloc_item(RT_A64_LDST, 64'hFF8, 0, 0, b64, 4, '1));
		pending_relocs.push_back(reloc_item(RT_A64_LDST, 64'h4, 0, 0, b64, 2, 0));
		pending_relocs.push_back(reloc_item(RT_X86_64, 0, 0, 0, b64, 8, 0));
		pending_relocs.push_back(reloc_item(RT_A64_LDST, 64'h4, 0, 8, b64, 8, 0));
		drain();

		// Random phases alternate the architecture and the idling pattern.
		for (int ph = 0; ph < 5; ph++) begin
			wval    = $urandom;
			wval[0] = ph[0];
			write_arch(wval);
			send_burst = (ph == 2 || ph == 3);
			recv_burst = (ph == 2 || ph == 4);
			for (int i = 0; i < PhaseLen; i++)
				pending_relocs.push_back(rand_reloc(arch_model));
			drain();
		end

		repeat (8) @(posedge clk);
		$display("covered %0d relocations under %0d architecture settings, %0d results checked",
			n_sent, n_settings, n_checked);
		$display("errors: %0d", n_errors);
		if (n_errors == 0 && expected_patches.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#5000000;
		$display("status: fail");
		$finish;
	end

endmodule

// ----- relocation_patch_unit.f -----
sv/rpu_pkg.sv
sv/rpu_addr_stage.sv
sv/rpu_diff_stage.sv
sv/rpu_patch_stage.sv
sv/relocation_patch_unit.sv
tb/testbench.sv
